// File: hdl/ral_pkg.sv
// shared types, codes and constants of the request admission limiter
package ral_pkg;

  localparam int unsigned RingDepth = 64;
  localparam int unsigned StampW    = 48;
  localparam int unsigned WindowW   = 32;
  localparam int unsigned CountW    = 32;
  localparam int unsigned SumW      = 48;
  localparam int unsigned InFlightW = 16;
  localparam int unsigned RateW     = 7;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [9:0]         FailStatus     = 10'd400;
  localparam logic [WindowW-1:0] WindowReset    = 32'd60000;
  localparam logic [31:0]        MaxBytesReset  = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_REQUEST  = 2'd0,
    OP_COMPLETE = 2'd1,
    OP_RESPONSE = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    V_OK            = 3'd0,
    V_REQ_TOO_LARGE = 3'd1,
    V_RATE_LIMITED  = 3'd2,
    V_TOO_MANY      = 3'd3,
    V_RESP_TOO_LARGE = 3'd4
  } verdict_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_REQ_PER_WINDOW = 3'd0,
    CFG_WINDOW_LENGTH      = 3'd1,
    CFG_MAX_IN_FLIGHT      = 3'd2,
    CFG_MAX_REQ_BYTES      = 3'd3,
    CFG_MAX_RESP_BYTES     = 3'd4
  } cfg_reg_e;

  // commands from the sequencer to the timestamp ring
  typedef struct packed {
    logic              pop;
    logic              push;
    logic [StampW-1:0] stamp;
  } ring_ctrl_t;

endpackage

// File: hdl/ral_ring.sv
// timestamp ring: one synchronous memory with oldest pointer and fill count
module ral_ring #(
  parameter int unsigned RING_DEPTH = ral_pkg::RingDepth,
  localparam int unsigned PtrW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1,
  localparam int unsigned FillW = $clog2(RING_DEPTH + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ral_pkg::ring_ctrl_t          ctrl_i,
  output logic [FillW-1:0]             fill_o,
  output logic [ral_pkg::StampW-1:0]   head_o
);

  logic [PtrW-1:0]            oldest_q, oldest_d, oldest_inc, wr_addr;
  logic [FillW-1:0]           fill_q, fill_d;
  logic [FillW:0]             slot_sum;
  logic                       full;
  logic [ral_pkg::StampW-1:0] ring_mem [RING_DEPTH];
  logic [ral_pkg::StampW-1:0] head_q;

  assign oldest_inc = (oldest_q == PtrW'(RING_DEPTH - 1)) ? '0 : oldest_q + 1'b1;
  assign full       = (fill_q == FillW'(RING_DEPTH));

  // slot after the newest entry, oldest + fill wrapped once
  assign slot_sum = (FillW + 1)'(oldest_q) + (FillW + 1)'(fill_q);
  assign wr_addr  = (slot_sum >= (FillW + 1)'(RING_DEPTH)) ?
                    PtrW'(slot_sum - (FillW + 1)'(RING_DEPTH)) : PtrW'(slot_sum);

  always_comb begin
    oldest_d = oldest_q;
    fill_d   = fill_q;
    if (ctrl_i.pop) begin
      oldest_d = oldest_inc;
      fill_d   = fill_q - 1'b1;
    end else if (ctrl_i.push) begin
      if (full) begin
        oldest_d = oldest_inc;
      end else begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q <= '0;
      fill_q   <= '0;
    end else begin
      oldest_q <= oldest_d;
      fill_q   <= fill_d;
    end
  end

  // head is read at the next oldest slot so a pop is seen in the registered head in the cycle after it
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      ring_mem[wr_addr] <= ctrl_i.stamp;
    end
    head_q <= ring_mem[oldest_d];
  end

  assign fill_o = fill_q;
  assign head_o = head_q;

endmodule

// File: hdl/request_admission_limiter_unit.sv
// top level of the request admission limiter
//
// admission control for outgoing requests, one event word at a time:
// a request, a request completion or a response check
// input channel: in_valid_i / in_ready_o with operation, time in ms, body
// size and status code; output channel: out_valid_o / out_ready_i with the
// verdict and a snapshot of all counters after the word
// configuration: cfg_valid_i / cfg_ready_o, register index and data, taken
// at any time but only meant to be written while the block is idle
// sequence: an accepted word goes to the final step directly when no window
// walk is needed; a request that walks the window first drops expired stamps
// from the oldest on until one stays or the memory is empty, and the result
// is registered in the final step; one stamp is read per cycle
// the input side is ready whenever no word is in work, even while a result
// waits; a stalled receiver holds the next word in its final step until the
// result is taken, and the counters shown never change under a waiting result
// reset clears pointers, counters and the output valid and loads the register
// defaults; the stamp memory is not cleared, only written entries are read
module request_admission_limiter_unit #(
  parameter int unsigned RING_DEPTH = ral_pkg::RingDepth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ral_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ral_pkg::CfgDataW-1:0]   cfg_data_i,
  // event words
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     operation_i,
  input  logic [ral_pkg::StampW-1:0]     now_ms_i,
  input  logic [31:0]                    body_bytes_i,
  input  logic [9:0]                     status_code_i,
  // result words
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [2:0]                     verdict_o,
  output logic [ral_pkg::InFlightW-1:0]  in_flight_now_o,
  output logic [ral_pkg::CountW-1:0]     admitted_total_o,
  output logic [ral_pkg::CountW-1:0]     blocked_total_o,
  output logic [ral_pkg::CountW-1:0]     failed_total_o,
  output logic [ral_pkg::SumW-1:0]       bytes_in_total_o,
  output logic [ral_pkg::SumW-1:0]       bytes_out_total_o
);

  localparam int unsigned FillW = $clog2(RING_DEPTH + 1);
  localparam int unsigned CmpW  = (FillW > ral_pkg::RateW) ? FillW : ral_pkg::RateW;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_PURGE = 3'b010,
    S_DONE  = 3'b100
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [ral_pkg::RateW-1:0]     max_rpw_q;
  logic [ral_pkg::WindowW-1:0]   window_q;
  logic [ral_pkg::InFlightW-1:0] max_if_q;
  logic [31:0]                   max_req_bytes_q;
  logic [31:0]                   max_resp_bytes_q;

  // word in work
  ral_pkg::op_e               op_q;
  logic [ral_pkg::StampW-1:0] now_q;
  logic [31:0]                bytes_q;
  logic [9:0]                 status_q;
  logic                       big_q;

  // running state
  logic [ral_pkg::InFlightW-1:0] in_flight_q, in_flight_d;
  logic [ral_pkg::CountW-1:0]    admitted_q, admitted_d;
  logic [ral_pkg::CountW-1:0]    blocked_q, blocked_d;
  logic [ral_pkg::CountW-1:0]    failed_q, failed_d;
  logic [ral_pkg::SumW-1:0]      bytes_in_q, bytes_in_d;
  logic [ral_pkg::SumW-1:0]      bytes_out_q, bytes_out_d;

  ral_pkg::verdict_e verdict_q, verdict_d;
  logic              out_valid_q, out_valid_d;

  ral_pkg::ring_ctrl_t        ring_ctrl;
  logic [FillW-1:0]           ring_fill;
  logic [ral_pkg::StampW-1:0] ring_head;

  logic                     in_fire, fin, expired, rate_hit, conc_hit;
  logic                     req_big_in, resp_big_in, purge_go, admit;
  logic [ral_pkg::SumW:0]   stamp_end, in_sum, out_sum;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_rpw_q        <= '0;
      window_q         <= ral_pkg::WindowReset;
      max_if_q         <= '0;
      max_req_bytes_q  <= ral_pkg::MaxBytesReset;
      max_resp_bytes_q <= ral_pkg::MaxBytesReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ral_pkg::CFG_MAX_REQ_PER_WINDOW: max_rpw_q        <= cfg_data_i[ral_pkg::RateW-1:0];
        ral_pkg::CFG_WINDOW_LENGTH:      window_q         <= cfg_data_i;
        ral_pkg::CFG_MAX_IN_FLIGHT:      max_if_q         <= cfg_data_i[ral_pkg::InFlightW-1:0];
        ral_pkg::CFG_MAX_REQ_BYTES:      max_req_bytes_q  <= cfg_data_i;
        ral_pkg::CFG_MAX_RESP_BYTES:     max_resp_bytes_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // size checks are done on the incoming word
  assign req_big_in  = (body_bytes_i > max_req_bytes_q);
  assign resp_big_in = (body_bytes_i > max_resp_bytes_q);

  // the window walk is needed only for a request of legal size with the
  // rate check enabled and at least one stamp stored
  assign purge_go = (operation_i == ral_pkg::OP_REQUEST) && !req_big_in &&
                    (max_rpw_q != '0) && (ring_fill != '0);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q     <= ral_pkg::op_e'(operation_i);
      now_q    <= now_ms_i;
      bytes_q  <= body_bytes_i;
      status_q <= status_code_i;
      big_q    <= (operation_i == ral_pkg::OP_REQUEST) ? req_big_in : resp_big_in;
    end
  end

  // oldest stamp has left the window when stamp + window < now
  assign stamp_end = {1'b0, ring_head} + (ral_pkg::SumW + 1)'(window_q);
  assign expired   = (stamp_end < {1'b0, now_q});

  assign fin = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = purge_go ? S_PURGE : S_DONE;
        end
      end
      S_PURGE: begin
        if (!expired || (ring_fill == FillW'(1))) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (fin) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign rate_hit = (max_rpw_q != '0) && (CmpW'(ring_fill) >= CmpW'(max_rpw_q));
  assign conc_hit = (max_if_q != '0) && (in_flight_q >= max_if_q);

  always_comb begin
    case (op_q)
      ral_pkg::OP_REQUEST: begin
        if (big_q) begin
          verdict_d = ral_pkg::V_REQ_TOO_LARGE;
        end else if (rate_hit) begin
          verdict_d = ral_pkg::V_RATE_LIMITED;
        end else if (conc_hit) begin
          verdict_d = ral_pkg::V_TOO_MANY;
        end else begin
          verdict_d = ral_pkg::V_OK;
        end
      end
      ral_pkg::OP_RESPONSE: verdict_d = big_q ? ral_pkg::V_RESP_TOO_LARGE : ral_pkg::V_OK;
      default:              verdict_d = ral_pkg::V_OK;
    endcase
  end

  assign admit = fin && (op_q == ral_pkg::OP_REQUEST) && (verdict_d == ral_pkg::V_OK);

  assign ring_ctrl.pop   = (state_q == S_PURGE) && expired;
  assign ring_ctrl.push  = admit;
  assign ring_ctrl.stamp = now_q;

  assign in_sum  = {1'b0, bytes_in_q} + (ral_pkg::SumW + 1)'(bytes_q);
  assign out_sum = {1'b0, bytes_out_q} + (ral_pkg::SumW + 1)'(bytes_q);

  // counter updates, all saturating
  always_comb begin
    in_flight_d = in_flight_q;
    admitted_d  = admitted_q;
    blocked_d   = blocked_q;
    failed_d    = failed_q;
    bytes_in_d  = bytes_in_q;
    bytes_out_d = bytes_out_q;
    if (fin) begin
      case (op_q)
        ral_pkg::OP_REQUEST: begin
          if (admit) begin
            if (admitted_q != '1) admitted_d = admitted_q + 1'b1;
            if (in_flight_q != '1) in_flight_d = in_flight_q + 1'b1;
            bytes_out_d = out_sum[ral_pkg::SumW] ? '1 : out_sum[ral_pkg::SumW-1:0];
          end else begin
            if (blocked_q != '1) blocked_d = blocked_q + 1'b1;
          end
        end
        ral_pkg::OP_COMPLETE: begin
          if (in_flight_q != '0) in_flight_d = in_flight_q - 1'b1;
        end
        ral_pkg::OP_RESPONSE: begin
          if (!big_q) begin
            bytes_in_d = in_sum[ral_pkg::SumW] ? '1 : in_sum[ral_pkg::SumW-1:0];
            if ((status_q >= ral_pkg::FailStatus) && (failed_q != '1)) begin
              failed_d = failed_q + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result handshake
  always_comb begin
    if (fin) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      verdict_q   <= ral_pkg::V_OK;
      in_flight_q <= '0;
      admitted_q  <= '0;
      blocked_q   <= '0;
      failed_q    <= '0;
      bytes_in_q  <= '0;
      bytes_out_q <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (fin) begin
        verdict_q <= verdict_d;
      end
      in_flight_q <= in_flight_d;
      admitted_q  <= admitted_d;
      blocked_q   <= blocked_d;
      failed_q    <= failed_d;
      bytes_in_q  <= bytes_in_d;
      bytes_out_q <= bytes_out_d;
    end
  end

  ral_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ring_ctrl),
    .fill_o (ring_fill),
    .head_o (ring_head)
  );

  // counters change only together with a new result, so they serve as the
  // result payload directly
  assign out_valid_o       = out_valid_q;
  assign verdict_o         = verdict_q;
  assign in_flight_now_o   = in_flight_q;
  assign admitted_total_o  = admitted_q;
  assign blocked_total_o   = blocked_q;
  assign failed_total_o    = failed_q;
  assign bytes_in_total_o  = bytes_in_q;
  assign bytes_out_total_o = bytes_out_q;

endmodule

// File: dv/ral_admission_checker.sv
// checker that predicts and compares every result word of the admission limiter
`timescale 1ns / 100ps
module ral_admission_checker
  import ral_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [1:0]           operation_i,
  input  logic [StampW-1:0]    now_ms_i,
  input  logic [31:0]          body_bytes_i,
  input  logic [9:0]           status_code_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [2:0]           verdict_i,
  input  logic [InFlightW-1:0] in_flight_now_i,
  input  logic [CountW-1:0]    admitted_total_i,
  input  logic [CountW-1:0]    blocked_total_i,
  input  logic [CountW-1:0]    failed_total_i,
  input  logic [SumW-1:0]      bytes_in_total_i,
  input  logic [SumW-1:0]      bytes_out_total_i,
  output int unsigned          mismatches_o,
  output int unsigned          pending_o
);

  typedef struct packed {
    verdict_e             verdict;
    logic [InFlightW-1:0] in_flight;
    logic [CountW-1:0]    admitted;
    logic [CountW-1:0]    blocked;
    logic [CountW-1:0]    failed;
    logic [SumW-1:0]      bytes_in;
    logic [SumW-1:0]      bytes_out;
  } tally_t;

  // predicted limiter state
  logic [StampW-1:0]    stamps [RingDepth];
  int unsigned          oldest;
  int unsigned          fill;
  logic [InFlightW-1:0] in_flight;
  logic [CountW-1:0]    admitted;
  logic [CountW-1:0]    blocked;
  logic [CountW-1:0]    failed;
  logic [SumW-1:0]      bytes_in;
  logic [SumW-1:0]      bytes_out;

  // register copies
  logic [RateW-1:0]     rate_limit;
  logic [WindowW-1:0]   window_ms;
  logic [InFlightW-1:0] flight_limit;
  logic [31:0]          req_limit;
  logic [31:0]          resp_limit;

  tally_t expected_tallies [$];

  function automatic logic [CountW-1:0] bump(logic [CountW-1:0] count);
    return (count == '1) ? count : count + 1'b1;
  endfunction

  function automatic logic [SumW-1:0] accumulate(logic [SumW-1:0] sum, logic [31:0] bytes);
    logic [SumW:0] wide;
    wide = {1'b0, sum} + (SumW+1)'(bytes);
    return wide[SumW] ? '1 : wide[SumW-1:0];
  endfunction

  function automatic tally_t judge_event(op_e op, logic [StampW-1:0] now,
                                         logic [31:0] bytes, logic [9:0] status);
    verdict_e verdict;
    bit       limited;
    tally_t   t;
    verdict = V_OK;
    limited = 1'b0;
    case (op)
      OP_REQUEST: begin
        // the window is only looked at once the size check passed
        if (bytes <= req_limit && rate_limit != '0) begin
          while (fill > 0 &&
                 ({1'b0, stamps[oldest]} + (StampW+1)'(window_ms)) < {1'b0, now}) begin
            oldest = (oldest + 1) % RingDepth;
            fill--;
          end
          limited = (fill >= rate_limit);
        end
        if (bytes > req_limit) verdict = V_REQ_TOO_LARGE;
        else if (limited) verdict = V_RATE_LIMITED;
        else if (flight_limit != '0 && in_flight >= flight_limit) verdict = V_TOO_MANY;
        if (verdict != V_OK) begin
          blocked = bump(blocked);
        end else begin
          // full ring loses its oldest stamp
          if (fill >= RingDepth) begin
            oldest = (oldest + 1) % RingDepth;
            fill   = RingDepth - 1;
          end
          stamps[(oldest + fill) % RingDepth] = now;
          fill++;
          admitted = bump(admitted);
          if (in_flight != '1) in_flight = in_flight + 1'b1;
          bytes_out = accumulate(bytes_out, bytes);
        end
      end
      OP_COMPLETE: begin
        if (in_flight != '0) in_flight = in_flight - 1'b1;
      end
      OP_RESPONSE: begin
        if (bytes > resp_limit) begin
          verdict = V_RESP_TOO_LARGE;
        end else begin
          bytes_in = accumulate(bytes_in, bytes);
          if (status >= FailStatus) failed = bump(failed);
        end
      end
      default: ;
    endcase
    t.verdict   = verdict;
    t.in_flight = in_flight;
    t.admitted  = admitted;
    t.blocked   = blocked;
    t.failed    = failed;
    t.bytes_in  = bytes_in;
    t.bytes_out = bytes_out;
    return t;
  endfunction

  task automatic note_field(string field, logic [SumW-1:0] want, logic [SumW-1:0] got);
    if (got !== want) begin
      mismatches_o++;
      if (mismatches_o <= 10)
        $display("%0t: %s expected %0h got %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tally_t want;
    if (!rst_ni) begin
      oldest       = 0;
      fill         = 0;
      in_flight    = '0;
      admitted     = '0;
      blocked      = '0;
      failed       = '0;
      bytes_in     = '0;
      bytes_out    = '0;
      rate_limit   = '0;
      window_ms    = WindowReset;
      flight_limit = '0;
      req_limit    = MaxBytesReset;
      resp_limit   = MaxBytesReset;
      expected_tallies.delete();
      mismatches_o = 0;
      pending_o    = 0;
    end else begin
      // result first: a word taken at this edge belongs to an older event
      if (out_valid_i && out_ready_i) begin
        if (expected_tallies.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("%0t: result word with nothing expected, verdict %0d", $time, verdict_i);
        end else begin
          want = expected_tallies[0];
          expected_tallies.delete(0);
          note_field("verdict", want.verdict, verdict_i);
          note_field("in_flight_now", want.in_flight, in_flight_now_i);
          note_field("admitted_total", want.admitted, admitted_total_i);
          note_field("blocked_total", want.blocked, blocked_total_i);
          note_field("failed_total", want.failed, failed_total_i);
          note_field("bytes_in_total", want.bytes_in, bytes_in_total_i);
          note_field("bytes_out_total", want.bytes_out, bytes_out_total_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MAX_REQ_PER_WINDOW: rate_limit   = cfg_data_i[RateW-1:0];
          CFG_WINDOW_LENGTH:      window_ms    = cfg_data_i[WindowW-1:0];
          CFG_MAX_IN_FLIGHT:      flight_limit = cfg_data_i[InFlightW-1:0];
          CFG_MAX_REQ_BYTES:      req_limit    = cfg_data_i[31:0];
          CFG_MAX_RESP_BYTES:     resp_limit   = cfg_data_i[31:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        expected_tallies.insert(expected_tallies.size(),
                                judge_event(op_e'(operation_i), now_ms_i,
                                            body_bytes_i, status_code_i));
      pending_o = expected_tallies.size();
    end
  end

endmodule

// File: dv/tb_request_admission_limiter_unit.sv
// testbench top: clock, reset, event traffic and final verdict for the admission limiter
`timescale 1ns / 100ps
module tb_request_admission_limiter_unit;
  import ral_pkg::*;

  localparam int unsigned CycleLimit = 500_000;
  localparam int unsigned IdlePct    = 19;
  localparam int unsigned DrainTail  = 100;  // longer than a full purge walk
  // register index with nothing behind it, writes must change nothing
  localparam logic [CfgIdxW-1:0] CfgSpare = 3'd7;

  logic                 clk;
  logic                 rst_n       = 1'b0;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  logic [CfgIdxW-1:0]   cfg_index   = '0;
  logic [CfgDataW-1:0]  cfg_data    = '0;
  logic                 in_valid    = 1'b0;
  logic                 in_ready;
  logic [1:0]           operation   = '0;
  logic [StampW-1:0]    now_ms      = '0;
  logic [31:0]          body_bytes  = '0;
  logic [9:0]           status_code = '0;
  logic                 out_valid;
  logic                 out_ready   = 1'b0;
  logic [2:0]           verdict;
  logic [InFlightW-1:0] in_flight_now;
  logic [CountW-1:0]    admitted_total;
  logic [CountW-1:0]    blocked_total;
  logic [CountW-1:0]    failed_total;
  logic [SumW-1:0]      bytes_in_total;
  logic [SumW-1:0]      bytes_out_total;

  int unsigned          mismatches;
  int unsigned          pending;
  int unsigned          cycle_count = 0;
  bit                   calm        = 1'b0;  // no idling on either side while set
  logic [StampW-1:0]    clock_ms    = '0;    // running time of well-formed traffic
  logic [31:0]          req_cap     = MaxBytesReset;
  logic [31:0]          resp_cap    = MaxBytesReset;

  request_admission_limiter_unit dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .operation_i       (operation),
    .now_ms_i          (now_ms),
    .body_bytes_i      (body_bytes),
    .status_code_i     (status_code),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .verdict_o         (verdict),
    .in_flight_now_o   (in_flight_now),
    .admitted_total_o  (admitted_total),
    .blocked_total_o   (blocked_total),
    .failed_total_o    (failed_total),
    .bytes_in_total_o  (bytes_in_total),
    .bytes_out_total_o (bytes_out_total)
  );

  ral_admission_checker checker_i (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .operation_i       (operation),
    .now_ms_i          (now_ms),
    .body_bytes_i      (body_bytes),
    .status_code_i     (status_code),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .verdict_i         (verdict),
    .in_flight_now_i   (in_flight_now),
    .admitted_total_i  (admitted_total),
    .blocked_total_i   (blocked_total),
    .failed_total_i    (failed_total),
    .bytes_in_total_i  (bytes_in_total),
    .bytes_out_total_i (bytes_out_total),
    .mismatches_o      (mismatches),
    .pending_o         (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stalls at random, never during the calm stretch
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= IdlePct);
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb_request_admission_limiter_unit: errors");
      $finish;
    end
  end

  // register write, entered and left at a falling edge
  task automatic write_reg(logic [CfgIdxW-1:0] index, logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // hold off new words until every expected result word is back
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // registers only change with the block idle
  task automatic set_limits(logic [RateW-1:0] rate, logic [WindowW-1:0] window,
                            logic [InFlightW-1:0] flight, logic [31:0] req,
                            logic [31:0] resp);
    wait_drain();
    write_reg(CFG_MAX_REQ_PER_WINDOW, CfgDataW'(rate));
    write_reg(CFG_WINDOW_LENGTH, CfgDataW'(window));
    write_reg(CFG_MAX_IN_FLIGHT, CfgDataW'(flight));
    write_reg(CFG_MAX_REQ_BYTES, req);
    write_reg(CFG_MAX_RESP_BYTES, resp);
    req_cap  = req;
    resp_cap = resp;
  endtask

  // one event word; valid stays up across back-to-back words
  task automatic send_word(op_e op, logic [StampW-1:0] now, logic [31:0] bytes,
                           logic [9:0] status);
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    now_ms      <= now;
    body_bytes  <= bytes;
    status_code <= status;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // mostly well-formed traffic: time creeps forward, bursts share a ms
  task automatic random_events(int unsigned count, int unsigned step_max);
    int unsigned       n;
    int unsigned       roll;
    op_e               op;
    logic [StampW-1:0] now;
    logic [31:0]       bytes;
    logic [9:0]        status;
    for (n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) op = OP_REQUEST;
      else if (roll < 75) op = OP_COMPLETE;
      else if (roll < 95) op = OP_RESPONSE;
      else op = OP_NONE;

      roll = $urandom_range(0, 99);
      if (roll >= 40 && roll < 97) begin
        clock_ms = clock_ms + $urandom_range(1, step_max);
      end else if (roll < 99 && roll >= 97) begin
        // time going backwards a little
        if (clock_ms > 20) clock_ms = clock_ms - $urandom_range(1, 20);
      end else if (roll == 99) begin
        clock_ms = clock_ms + $urandom_range(0, 100000);
      end
      now = clock_ms;
      // wild times only where they cannot poison the stamp ring
      if (op != OP_REQUEST && $urandom_range(0, 99) < 10)
        now = StampW'({$urandom, $urandom});

      roll = $urandom_range(0, 99);
      if (roll < 25) bytes = '0;
      else if (roll < 65) bytes = $urandom_range(1, 4096);
      else if (roll < 85) bytes = ((op == OP_RESPONSE) ? resp_cap : req_cap)
                                  + $urandom_range(0, 2) - 1;
      else bytes = $urandom;

      if ($urandom_range(0, 99) < 60) status = $urandom_range(390, 410);
      else status = $urandom_range(0, 999);

      if ($urandom_range(0, 199) == 0) wait_drain();
      send_word(op, now, bytes, status);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset defaults: no rate or concurrency limit, all sizes pass
    send_word(OP_REQUEST, 48'd0, 32'd0, 10'd0);
    send_word(OP_REQUEST, 48'd1, 32'hFFFF_FFFF, 10'd999);
    send_word(OP_COMPLETE, 48'd2, 32'd0, 10'd0);
    send_word(OP_COMPLETE, 48'd2, 32'd0, 10'd0);
    // completion with nothing in flight
    send_word(OP_COMPLETE, 48'd2, 32'd0, 10'd0);
    send_word(OP_RESPONSE, 48'd3, 32'hFFFF_FFFF, 10'd999);
    send_word(OP_RESPONSE, 48'd3, 32'd1, 10'd399);
    send_word(OP_RESPONSE, 48'd3, 32'd0, 10'd400);
    // unused code, time and body size at their top
    send_word(OP_NONE, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 10'd999);

    // tight limits to hit each refusal
    set_limits(7'd2, 32'd100, 16'd1, 32'd100, 32'd100);
    send_word(OP_REQUEST, 48'd1000, 32'd101, 10'd0);   // too large
    send_word(OP_REQUEST, 48'd1000, 32'd100, 10'd0);   // purges old stamps, admitted
    send_word(OP_REQUEST, 48'd1001, 32'd5, 10'd0);     // concurrency limit
    send_word(OP_COMPLETE, 48'd1001, 32'd0, 10'd0);
    send_word(OP_REQUEST, 48'd1002, 32'd5, 10'd0);
    send_word(OP_COMPLETE, 48'd1002, 32'd0, 10'd0);
    send_word(OP_REQUEST, 48'd1050, 32'd5, 10'd0);     // window full
    send_word(OP_REQUEST, 48'd1101, 32'd5, 10'd0);     // one stamp expired
    send_word(OP_RESPONSE, 48'd1101, 32'd101, 10'd200); // response too large
    send_word(OP_RESPONSE, 48'd1101, 32'd100, 10'd500);
    send_word(OP_REQUEST, 48'd500, 32'd5, 10'd0);      // time going backwards

    clock_ms = 48'd2000;

    // defaults restored explicitly, ring wraps with the rate check off
    set_limits(7'd0, 32'd60000, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    write_reg(CfgSpare, 32'hFFFF_FFFF);
    random_events(250, 1000);

    set_limits(7'd4, 32'd1000, 16'd3, 32'd65536, 32'd65536);
    random_events(300, 400);

    // shortest window, deepest purge walks
    set_limits(7'd64, 32'd1, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_0000);
    random_events(250, 3);

    // limit beyond the ring depth, endless window, only empty bodies pass
    set_limits(7'd127, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, 32'd0);
    calm = 1'b1;
    random_events(250, 500);
    wait_drain();
    calm = 1'b0;

    set_limits(7'd1, 32'd50, 16'd1, 32'hFFFF_FFFF, 32'd1000);
    random_events(300, 40);

    set_limits(7'd16, 32'd5000, 16'd8, 32'd1048576, 32'd16777216);
    random_events(300, 300);

    wait_drain();
    repeat (DrainTail) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_request_admission_limiter_unit: clean");
    end else begin
      $display("tb_request_admission_limiter_unit: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/ral_pkg.sv
hdl/ral_ring.sv
hdl/request_admission_limiter_unit.sv
dv/ral_admission_checker.sv
dv/tb_request_admission_limiter_unit.sv
